@@ sv/nfet_pkg.sv @@
// ----------------------------------------------------------------------------
// nfet_pkg
// Shared types and constants for the nearest fresh entry tracker: request
// and response beats, configuration registers, slot record and codes.
// ----------------------------------------------------------------------------
package nfet_pkg;

   // default number of tracked slots
   localparam int SLOT_COUNT_DEF = 8;

   // request operation codes
   localparam logic OP_OBSERVE = 1'b0;
   localparam logic OP_UPDATE  = 1'b1;

   // configuration register indexes
   localparam logic [1:0] CSR_TIMEOUT = 2'd0;
   localparam logic [1:0] CSR_FOUND   = 2'd1;
   localparam logic [1:0] CSR_NEAR    = 2'd2;

   // configuration reset values
   localparam logic [31:0] TIMEOUT_RST = 32'd10000;
   localparam logic [15:0] FOUND_RST   = 16'd100;
   localparam logic [15:0] NEAR_RST    = 16'd300;

   // proximity class codes
   localparam logic [1:0] PROX_AMBIENT  = 2'd0;
   localparam logic [1:0] PROX_FOUND    = 2'd1;
   localparam logic [1:0] PROX_NEAR     = 2'd2;
   localparam logic [1:0] PROX_DETECTED = 2'd3;

   // request beat
   typedef struct packed {
      logic        operation;
      logic [7:0]  entry_id;
      logic [15:0] distance_cm;
      logic [31:0] now_ms;
   } req_type;

   // response beat
   typedef struct packed {
      logic        any_visible;
      logic [2:0]  nearest_id;
      logic [15:0] nearest_distance_cm;
      logic [1:0]  proximity_class;
   } rsp_type;

   // configuration register set
   typedef struct packed {
      logic [31:0] timeout_ms;
      logic [15:0] found_threshold_cm;
      logic [15:0] near_threshold_cm;
   } cfg_type;

   // one slot record as kept in memory
   typedef struct packed {
      logic [15:0] distance_cm;
      logic [31:0] last_seen_ms;
   } slot_type;

endpackage

@@ sv/nearest_fresh_entry_tracker.sv @@
// ----------------------------------------------------------------------------
// nearest_fresh_entry_tracker
// Slot table of distances and last-seen times, with aging and a nearest
// visible slot report on each update request.
// ----------------------------------------------------------------------------
// Observe: written at the accepting edge, no response.
// Update: busy while the table memory is walked one slot per cycle in ST_SCAN,
//   then through ST_DRAIN and ST_REPORT; the response strobe is registered
//   from ST_REPORT, and no new request is taken until the block is idle again.
// The receiver cannot stall: each response is shown for exactly one cycle.
// Reset clears all visibility flags and loads the register defaults at once.
module nearest_fresh_entry_tracker #(
   parameter int SLOT_COUNT = nfet_pkg::SLOT_COUNT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  nfet_pkg::req_type req,
   output logic              rsp_valid,
   output nfet_pkg::rsp_type rsp,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_data
);
   import nfet_pkg::*;

   localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   cfg_type          cfg;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   slot_type         wr_data;
   logic [IDX_W-1:0] rd_addr;
   slot_type         rd_data;

   // configuration registers
   nfet_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // slot table
   nfet_slot_mem #(
      .SLOT_COUNT (SLOT_COUNT),
      .IDX_W      (IDX_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // request sequencer and nearest search
   nfet_scan #(
      .SLOT_COUNT (SLOT_COUNT),
      .IDX_W      (IDX_W)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req       (req),
      .cfg       (cfg),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

endmodule

@@ sv/nfet_csr.sv @@
// ----------------------------------------------------------------------------
// nfet_csr
// Configuration registers: timeout and the two proximity thresholds.
// ----------------------------------------------------------------------------
module nfet_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [31:0]      csr_data,
   output nfet_pkg::cfg_type cfg
);
   import nfet_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // registers are always writable
   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // register write decode, unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_TIMEOUT: cfg_in.timeout_ms         = csr_data;
            CSR_FOUND:   cfg_in.found_threshold_cm = csr_data[15:0];
            CSR_NEAR:    cfg_in.near_threshold_cm  = csr_data[15:0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_ms         <= TIMEOUT_RST;
         cfg_ff.found_threshold_cm <= FOUND_RST;
         cfg_ff.near_threshold_cm  <= NEAR_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ sv/nfet_slot_mem.sv @@
// ----------------------------------------------------------------------------
// nfet_slot_mem
// Slot table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module nfet_slot_mem #(
   parameter int SLOT_COUNT = nfet_pkg::SLOT_COUNT_DEF,
   parameter int IDX_W      = 3
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [IDX_W-1:0]  wr_addr,
   input  nfet_pkg::slot_type wr_data,
   input  logic [IDX_W-1:0]  rd_addr,
   output nfet_pkg::slot_type rd_data
);
   import nfet_pkg::*;

   slot_type mem [SLOT_COUNT];
   slot_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/nfet_scan.sv @@
// ----------------------------------------------------------------------------
// nfet_scan
// Request sequencer: writes observed slots, walks the table on an update,
// ages out stale slots, tracks the nearest visible one and reports it.
// ----------------------------------------------------------------------------
module nfet_scan #(
   parameter int SLOT_COUNT = nfet_pkg::SLOT_COUNT_DEF,
   parameter int IDX_W      = 3
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  nfet_pkg::req_type  req,
   input  nfet_pkg::cfg_type  cfg,
   output logic               wr_en,
   output logic [IDX_W-1:0]   wr_addr,
   output nfet_pkg::slot_type wr_data,
   output logic [IDX_W-1:0]   rd_addr,
   input  nfet_pkg::slot_type rd_data,
   output logic               rsp_valid,
   output nfet_pkg::rsp_type  rsp
);
   import nfet_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_REPORT = 4'b1000
   } state_type;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

   state_type             state_ff, state_in;
   logic [IDX_W-1:0]      scan_idx_ff, scan_idx_in;
   logic [IDX_W-1:0]      chk_idx_ff;
   logic                  chk_valid_ff;
   logic [31:0]           now_ff, now_in;
   logic [SLOT_COUNT-1:0] visible_ff, visible_in;
   logic                  found_ff, found_in;
   logic [IDX_W-1:0]      best_idx_ff, best_idx_in;
   logic [15:0]           best_dist_ff, best_dist_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic                  accept;
   logic                  in_range;
   logic [31:0]           age;
   logic                  expired;
   logic                  keep;
   logic                  take;
   logic [1:0]            prox;

   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start && !busy;
   assign in_range = ({1'b0, req.entry_id} < 9'(SLOT_COUNT));

   // observe writes straight into the table
   assign wr_en   = accept && (req.operation == OP_OBSERVE) && in_range;
   assign wr_addr = req.entry_id[IDX_W-1:0];
   assign wr_data = '{distance_cm: req.distance_cm, last_seen_ms: req.now_ms};
   assign rd_addr = scan_idx_ff;

   // age check and nearest compare on the slot read last cycle
   assign age     = now_ff - rd_data.last_seen_ms;
   assign expired = (age > cfg.timeout_ms);
   assign keep    = visible_ff[chk_idx_ff] && !expired;
   assign take    = chk_valid_ff && keep && (!found_ff || (rd_data.distance_cm < best_dist_ff));

   // proximity classification of the winner
   always_comb begin
      if (best_dist_ff < cfg.found_threshold_cm) begin
         prox = PROX_FOUND;
      end else if (best_dist_ff < cfg.near_threshold_cm) begin
         prox = PROX_NEAR;
      end else begin
         prox = PROX_DETECTED;
      end
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      scan_idx_in = scan_idx_ff;
      now_in      = now_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req.operation == OP_UPDATE)) begin
               state_in    = ST_SCAN;
               scan_idx_in = '0;
               now_in      = req.now_ms;
            end
         end
         ST_SCAN: begin
            if (scan_idx_ff == LAST_IDX) begin
               state_in = ST_DRAIN;
            end else begin
               scan_idx_in = scan_idx_ff + 1'b1;
            end
         end
         ST_DRAIN:  state_in = ST_REPORT;
         ST_REPORT: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // visibility flags: set on observe, cleared when aged out
   always_comb begin
      visible_in = visible_ff;
      if (wr_en) begin
         visible_in[wr_addr] = 1'b1;
      end
      if (chk_valid_ff) begin
         visible_in[chk_idx_ff] = keep;
      end
   end

   // nearest tracking, cleared at the start of each update
   always_comb begin
      found_in     = found_ff;
      best_idx_in  = best_idx_ff;
      best_dist_in = best_dist_ff;
      if (state_ff == ST_IDLE) begin
         found_in     = 1'b0;
         best_idx_in  = '0;
         best_dist_in = '0;
      end else if (take) begin
         found_in     = 1'b1;
         best_idx_in  = chk_idx_ff;
         best_dist_in = rd_data.distance_cm;
      end
   end

   // response beat
   always_comb begin
      rsp_valid_in = (state_ff == ST_REPORT);
      rsp_in       = rsp_ff;
      if (state_ff == ST_REPORT) begin
         if (found_ff) begin
            rsp_in.any_visible         = 1'b1;
            rsp_in.nearest_id          = 3'(best_idx_ff);
            rsp_in.nearest_distance_cm = best_dist_ff;
            rsp_in.proximity_class     = prox;
         end else begin
            rsp_in.any_visible         = 1'b0;
            rsp_in.nearest_id          = '0;
            rsp_in.nearest_distance_cm = '0;
            rsp_in.proximity_class     = PROX_AMBIENT;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         visible_ff   <= '0;
         chk_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         visible_ff   <= visible_in;
         chk_valid_ff <= (state_ff == ST_SCAN);
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      scan_idx_ff  <= scan_idx_in;
      chk_idx_ff   <= scan_idx_ff;
      now_ff       <= now_in;
      best_idx_ff  <= best_idx_in;
      best_dist_ff <= best_dist_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

@@ sv/nfet_checker.sv @@
// ----------------------------------------------------------------------------
// nfet_checker
// Port-level checks of the tracker's request and response behavior.
// ----------------------------------------------------------------------------
module nfet_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input nfet_pkg::req_type req,
   input logic              rsp_valid,
   input nfet_pkg::rsp_type rsp
);
   import nfet_pkg::*;

   // an update beat makes the block busy
   a_update_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req.operation == OP_UPDATE)) |=> busy)
      else $error("update accepted but block not busy");

   // an observe beat leaves the block free
   a_observe_free: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req.operation == OP_OBSERVE)) |=> !busy)
      else $error("observe beat made block busy");

   // response strobes are single cycles
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held for two cycles");

   // an empty result carries all zero fields
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp.any_visible) |->
         ((rsp.nearest_id == 3'd0) && (rsp.nearest_distance_cm == 16'd0) &&
          (rsp.proximity_class == PROX_AMBIENT)))
      else $error("empty result with nonzero fields");

   // a visible result is never ambient
   a_visible_class: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp.any_visible) |-> (rsp.proximity_class != PROX_AMBIENT))
      else $error("visible result classed ambient");

endmodule

bind nearest_fresh_entry_tracker nfet_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req       (req),
   .rsp_valid (rsp_valid),
   .rsp       (rsp)
);
